>>> hw/rtl/brb_pkg.sv
// Shared types and constants for the byte ring buffer with peek.
// Used by brb_ctrl, brb_outq and the top level; depends on nothing else.
`timescale 1ns / 1ps

package brb_pkg;

    localparam int BYTE_W   = 8;
    localparam int CAP_W    = 9;
    localparam int LEN_W    = 7;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 2;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;

    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_DATA  = 2'd2;

    typedef enum logic [0:0] {
        S_IDLE,
        S_BURST
    } ctrl_state_t;

    // Everything about a result except the byte, which may come from the store.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              last;
        logic              from_mem;
        logic [CAP_W-1:0]  stored;
        logic [CAP_W-1:0]  free;
        logic              empty;
        logic              full;
    } meta_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        meta_t             meta;
    } result_t;

    function automatic meta_t make_meta(
        input logic [STAT_W-1:0] status,
        input logic              last,
        input logic              from_mem,
        input logic [CAP_W-1:0]  cnt,
        input logic [CAP_W-1:0]  cap
    );
        meta_t m;
        m.status   = status;
        m.last     = last;
        m.from_mem = from_mem;
        m.stored   = cnt;
        m.free     = cap - cnt;
        m.empty    = (cnt == '0);
        m.full     = (cnt == cap);
        return m;
    endfunction

endpackage

>>> hw/rtl/brb_store.sv
// Byte store of the ring buffer: one write port, one registered read port.
// Stand-alone synchronous memory; no package dependency.
`timescale 1ns / 1ps

module brb_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/brb_outq.sv
// Four-entry result queue between the store read stage and the output channel.
// Depends on brb_pkg for the result and meta types.
`timescale 1ns / 1ps

module brb_outq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  brb_pkg::meta_t               push_meta,
    input  logic [brb_pkg::BYTE_W-1:0]   mem_rdata,
    input  logic                         pop_ready,
    output logic                         pop_valid,
    output brb_pkg::result_t             head,
    output logic [brb_pkg::QCNT_W-1:0]   count
);

    brb_pkg::result_t            q [brb_pkg::QDEPTH];
    brb_pkg::result_t            push_res;
    logic [brb_pkg::QPTR_W-1:0]  wptr_reg;
    logic [brb_pkg::QPTR_W-1:0]  wptr_next;
    logic [brb_pkg::QPTR_W-1:0]  rptr_reg;
    logic [brb_pkg::QPTR_W-1:0]  rptr_next;
    logic [brb_pkg::QCNT_W-1:0]  cnt_reg;
    logic [brb_pkg::QCNT_W-1:0]  cnt_next;
    logic                        pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (cnt_reg != '0);
    assign head      = q[rptr_reg];
    assign count     = cnt_reg;

    always_comb
    begin
        push_res.meta      = push_meta;
        push_res.read_byte = push_meta.from_mem ? mem_rdata : '0;
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + brb_pkg::QCNT_W'(push) - brb_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q[wptr_reg] <= push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

>>> hw/rtl/brb_ctrl.sv
// Request sequencer of the ring buffer: pointers, count, capacity and bursts.
// Drives the store ports and a one-entry stage that feeds brb_outq; uses brb_pkg.
`timescale 1ns / 1ps

module brb_ctrl #(
    parameter int USED_DEPTH = 256,
    parameter int AW         = 8,
    parameter int MAX_BURST  = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [brb_pkg::ACT_W-1:0]    action,
    input  logic [brb_pkg::BYTE_W-1:0]   write_byte,
    input  logic [brb_pkg::LEN_W-1:0]    burst_length,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [brb_pkg::CAP_W-1:0]    cfg_data,
    input  logic [brb_pkg::QCNT_W-1:0]   q_count,
    output logic                         mem_we,
    output logic [AW-1:0]                mem_waddr,
    output logic [brb_pkg::BYTE_W-1:0]   mem_wdata,
    output logic                         mem_re,
    output logic [AW-1:0]                mem_raddr,
    output logic                         pend_valid,
    output brb_pkg::meta_t               pend_meta
);

    localparam logic [brb_pkg::CAP_W:0]   LIMIT   = (brb_pkg::CAP_W + 1)'(USED_DEPTH);
    localparam logic [brb_pkg::CAP_W-1:0] CAP_RST = brb_pkg::CAP_W'(USED_DEPTH);
    localparam logic [brb_pkg::LEN_W-1:0] LEN_MAX = brb_pkg::LEN_W'(MAX_BURST);

    brb_pkg::ctrl_state_t          state_reg;
    brb_pkg::ctrl_state_t          state_next;
    logic [brb_pkg::CAP_W-1:0]     cap_reg;
    logic [brb_pkg::CAP_W-1:0]     cap_next;
    logic [brb_pkg::CAP_W-1:0]     cnt_reg;
    logic [brb_pkg::CAP_W-1:0]     cnt_next;
    logic [AW-1:0]                 rp_reg;
    logic [AW-1:0]                 rp_next;
    logic [AW-1:0]                 wp_reg;
    logic [AW-1:0]                 wp_next;
    logic [AW-1:0]                 addr_reg;
    logic [AW-1:0]                 addr_next;
    logic [AW-1:0]                 addr_inc;
    logic [brb_pkg::LEN_W-1:0]     remain_reg;
    logic [brb_pkg::LEN_W-1:0]     remain_next;
    logic                          consume_reg;
    logic                          consume_next;
    logic                          pend_valid_reg;
    logic                          pend_valid_next;
    brb_pkg::meta_t                pend_reg;
    brb_pkg::meta_t                pend_next;
    logic                          credit_ok;
    logic                          accept;
    logic                          is_burst_act;
    logic                          enough_data;
    logic                          burst_last;
    logic [brb_pkg::LEN_W-1:0]     len_fix;
    logic [brb_pkg::CAP_W:0]       cap_round;
    logic [brb_pkg::CAP_W-1:0]     cap_eff;

    function automatic logic [AW-1:0] wrap_inc(
        input logic [AW-1:0]               p,
        input logic [brb_pkg::CAP_W-1:0]   c
    );
        logic [brb_pkg::CAP_W-1:0] n;
        n = brb_pkg::CAP_W'(p) + 1'b1;
        return (n == c) ? '0 : n[AW-1:0];
    endfunction

    // The queue must have room for every result already issued plus this one.
    assign credit_ok = ({1'b0, q_count} + (brb_pkg::QCNT_W + 1)'(pend_valid_reg))
                       < (brb_pkg::QCNT_W + 1)'(brb_pkg::QDEPTH);
    // A register write takes the idle cycle; a request offered with it waits.
    assign cfg_ready = (state_reg == brb_pkg::S_IDLE);
    assign in_ready  = (state_reg == brb_pkg::S_IDLE) && credit_ok && !cfg_valid;
    assign accept    = in_valid && in_ready;

    assign len_fix = (burst_length == '0) ? brb_pkg::LEN_W'(1) :
                     (burst_length > LEN_MAX) ? LEN_MAX : burst_length;
    assign is_burst_act = (action == brb_pkg::ACT_READ) || (action == brb_pkg::ACT_PEEK);
    assign enough_data  = (cnt_reg >= brb_pkg::CAP_W'(len_fix));
    assign burst_last   = (remain_reg == brb_pkg::LEN_W'(1));
    assign addr_inc     = wrap_inc(addr_reg, cap_reg);

    // Capacity written by the host is rounded up to a multiple of four and clamped.
    always_comb
    begin
        cap_round = ({1'b0, cfg_data} + (brb_pkg::CAP_W + 1)'(3)) & ~(brb_pkg::CAP_W + 1)'(3);
        if (cap_round < (brb_pkg::CAP_W + 1)'(4))
        begin
            cap_round = (brb_pkg::CAP_W + 1)'(4);
        end
        if (cap_round > LIMIT)
        begin
            cap_round = LIMIT;
        end
        cap_eff = cap_round[brb_pkg::CAP_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brb_pkg::S_IDLE:
            begin
                if (accept && is_burst_act && enough_data)
                begin
                    state_next = brb_pkg::S_BURST;
                end
            end
            brb_pkg::S_BURST:
            begin
                if (credit_ok && burst_last)
                begin
                    state_next = brb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = brb_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cap_next        = cap_reg;
        cnt_next        = cnt_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        addr_next       = addr_reg;
        remain_next     = remain_reg;
        consume_next    = consume_reg;
        pend_valid_next = 1'b0;
        pend_next       = pend_reg;
        mem_we          = 1'b0;
        mem_waddr       = wp_reg;
        mem_wdata       = write_byte;
        mem_re          = 1'b0;
        mem_raddr       = addr_reg;

        case (state_reg)
            brb_pkg::S_IDLE:
            begin
                if (cfg_valid)
                begin
                    cap_next = cap_eff;
                    cnt_next = '0;
                    rp_next  = '0;
                    wp_next  = '0;
                end
                else if (accept)
                begin
                    case (action)
                        brb_pkg::ACT_WRITE:
                        begin
                            pend_valid_next = 1'b1;
                            if (cnt_reg == cap_reg)
                            begin
                                pend_next = brb_pkg::make_meta(brb_pkg::STAT_NO_SPACE,
                                    1'b1, 1'b0, cnt_reg, cap_reg);
                            end
                            else
                            begin
                                mem_we   = 1'b1;
                                wp_next  = wrap_inc(wp_reg, cap_reg);
                                cnt_next = cnt_reg + 1'b1;
                                pend_next = brb_pkg::make_meta(brb_pkg::STAT_DONE,
                                    1'b1, 1'b0, cnt_next, cap_reg);
                            end
                        end
                        brb_pkg::ACT_READ, brb_pkg::ACT_PEEK:
                        begin
                            if (!enough_data)
                            begin
                                pend_valid_next = 1'b1;
                                pend_next = brb_pkg::make_meta(brb_pkg::STAT_NO_DATA,
                                    1'b1, 1'b0, cnt_reg, cap_reg);
                            end
                            else
                            begin
                                addr_next    = rp_reg;
                                remain_next  = len_fix;
                                consume_next = (action == brb_pkg::ACT_READ);
                                if (action == brb_pkg::ACT_READ)
                                begin
                                    cnt_next = cnt_reg - brb_pkg::CAP_W'(len_fix);
                                end
                            end
                        end
                        default:
                        begin
                            pend_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            brb_pkg::S_BURST:
            begin
                if (credit_ok)
                begin
                    mem_re          = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_next = brb_pkg::make_meta(brb_pkg::STAT_DONE, burst_last, 1'b1,
                        cnt_reg, cap_reg);
                    addr_next   = addr_inc;
                    remain_next = remain_reg - 1'b1;
                    if (burst_last && consume_reg)
                    begin
                        rp_next = addr_inc;
                    end
                end
            end
            default:
            begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    assign pend_valid = pend_valid_reg;
    assign pend_meta  = pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= brb_pkg::S_IDLE;
            cap_reg        <= CAP_RST;
            cnt_reg        <= '0;
            rp_reg         <= '0;
            wp_reg         <= '0;
            remain_reg     <= '0;
            consume_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            cnt_reg        <= cnt_next;
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            remain_reg     <= remain_next;
            consume_reg    <= consume_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        pend_reg <= pend_next;
    end

endmodule

>>> hw/rtl/byte_ring_buffer_with_peek.sv
// Byte ring buffer with peek: top level joining sequencer, byte store and result queue.
// Depends on brb_pkg, brb_ctrl, brb_store and brb_outq.
//
// Requests arrive on the s_axis channel: tuser selects write, read burst, peek burst
// or no action, tdata carries the byte to write and the burst length. Results leave on
// m_axis with the delivered byte and the fill state in tdata, the status in tuser
// and tlast on the final result of each request. The cfg channel sets the
// capacity in use and clears both pointers and the count; it is ready only while
// no burst is under way, and a request offered together with it waits.
// A write leaves the sequencer idle; its result passes through the pending stage
// into the output queue. A read or peek of N bytes holds the sequencer for the
// burst: it is set up on acceptance, then one store read per byte through the
// single read port of the memory, paused while the output queue lacks room. A
// refused request leaves the sequencer idle. After reset the capacity is the full store
// (at most 256 bytes), the buffer is empty and no result is pending. When the receiver
// stalls, up to four results wait in the output queue and the sequencer pauses.
`timescale 1ns / 1ps

module byte_ring_buffer_with_peek #(
    parameter int STORE_DEPTH = 256,
    parameter int MAX_BURST   = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] write_byte, [14:8] burst_length, [15] zero
    input  logic [brb_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // [1:0] action
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] read_byte, [16:8] bytes_stored, [25:17] bytes_free, [26] is_empty,
    // [27] is_full, [31:28] zero
    output logic [brb_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // [1:0] status
    output logic [1:0]                     m_axis_tuser,
    output logic                           m_axis_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [8:0]                     cfg_data
);

    localparam int USED_DEPTH = (STORE_DEPTH < 256) ? STORE_DEPTH : 256;
    localparam int AW         = $clog2(USED_DEPTH);

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [brb_pkg::BYTE_W-1:0]    mem_wdata;
    logic                          mem_re;
    logic [AW-1:0]                 mem_raddr;
    logic [brb_pkg::BYTE_W-1:0]    mem_rdata;
    logic                          pend_valid;
    brb_pkg::meta_t                pend_meta;
    logic [brb_pkg::QCNT_W-1:0]    q_count;
    brb_pkg::result_t              head;

    brb_ctrl #(
        .USED_DEPTH (USED_DEPTH),
        .AW         (AW),
        .MAX_BURST  (MAX_BURST)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .action       (s_axis_tuser),
        .write_byte   (s_axis_tdata[7:0]),
        .burst_length (s_axis_tdata[14:8]),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .q_count      (q_count),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .pend_valid   (pend_valid),
        .pend_meta    (pend_meta)
    );

    brb_store #(
        .DEPTH (USED_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    brb_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pend_valid),
        .push_meta (pend_meta),
        .mem_rdata (mem_rdata),
        .pop_ready (m_axis_tready),
        .pop_valid (m_axis_tvalid),
        .head      (head),
        .count     (q_count)
    );

    assign m_axis_tdata = {4'b0000, head.meta.full, head.meta.empty, head.meta.free,
                           head.meta.stored, head.read_byte};
    assign m_axis_tuser = head.meta.status;
    assign m_axis_tlast = head.meta.last;

endmodule
